>>> rtl/assert_macros.svh
// Assertion macros for the RTL modules of combination_rank; used by cr_dp.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cr_pkg.sv
// Package for combination_rank: item types, controller states, command and
// status groups, and the binomial table (modulo 2^15). No dependencies.
package cr_pkg;

  localparam int unsigned ElemFields = 8;
  localparam int unsigned ElemW      = 4;
  localparam int unsigned RankW      = 15;
  localparam int unsigned SizeW      = 6;   // holds set sizes up to 63
  localparam int unsigned TabRows    = 32;
  localparam int unsigned TabCols    = 8;

  typedef logic [4:0] set_size_t;

  typedef struct packed {
    logic [3:0] pick_count;
    logic [3:0] elem_0;
    logic [3:0] elem_1;
    logic [3:0] elem_2;
    logic [3:0] elem_3;
    logic [3:0] elem_4;
    logic [3:0] elem_5;
    logic [3:0] elem_6;
    logic [3:0] elem_7;
  } in_item_t;

  typedef struct packed {
    logic signed [RankW-1:0] rank;
    logic                    bad_subset;
  } out_item_t;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

  typedef logic [TabRows-1:0][TabCols-1:0][RankW-1:0] binom_tab_t;

  // Pascal's triangle; 15-bit wrap keeps the rank exact modulo 2^15
  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < TabRows; n++) begin
      for (int k = 0; k < TabCols; k++) begin
        if (k == 0) begin
          tab[n][k] = RankW'(1);
        end else if (n == 0) begin
          tab[n][k] = '0;
        end else begin
          tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BinomTab = build_binom();

  localparam logic [RankW-1:0] RankEmpty = {RankW{1'b1}};

endpackage

>>> rtl/cr_chan_if.sv
// Valid/ready channel interface used for all combination_rank ports.
// Payload type is set by the instantiating module; no other dependencies.
interface cr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cr_ctrl.sv
// Controller state machine for combination_rank: load, walk and finish.
// Depends on cr_pkg for the state type and the command/status groups.
module cr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cr_pkg::status_t status_i,
  output cr_pkg::cmd_t    cmd_o
);

  cr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      cr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cr_pkg::StRun;
        end
      end
      cr_pkg::StRun: begin
        if (!status_i.walk_done) begin
          cmd_o.step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = cr_pkg::StIdle;
        end
      end
      default: begin
        state_d = cr_pkg::StIdle;
      end
    endcase
  end

endmodule

>>> rtl/cr_dp.sv
// Datapath for combination_rank: set size register, subset check, element
// shift line, binomial accumulator and output register.
// Depends on cr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cr_dp #(
  parameter int unsigned MAX_SET  = 16,
  parameter int unsigned MAX_PICK = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cr_pkg::set_size_t cfg_data_i,
  input  cr_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cr_pkg::out_item_t out_data_o,
  input  cr_pkg::cmd_t      cmd_i,
  output cr_pkg::status_t   status_o
);

  localparam int unsigned EW = cr_pkg::ElemW;
  localparam int unsigned RW = cr_pkg::RankW;
  localparam int unsigned SW = cr_pkg::SizeW;
  localparam int unsigned NF = cr_pkg::ElemFields;

  cr_pkg::set_size_t set_size_q;
  logic [SW-1:0]     n_eff;
  logic [SW-1:0]     n_q;
  logic [EW-1:0]     elem_in [NF];
  logic [EW-1:0]     elem_q  [NF];
  logic [EW-1:0]     prev_q;
  logic [EW-1:0]     j_q;
  logic [3:0]        rem_q;
  logic [RW-1:0]     acc_q;
  logic              empty_q, bad_q, single_q;
  logic              bad_in;
  logic [SW-1:0]     row_full;
  logic [RW-1:0]     rank_res;
  logic              out_valid_q;
  cr_pkg::out_item_t out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= 5'd16;
    end else if (cfg_valid_i) begin
      set_size_q <= cfg_data_i;
    end
  end

  assign n_eff = ({1'b0, set_size_q} > SW'(MAX_SET)) ? SW'(MAX_SET) : {1'b0, set_size_q};

  assign elem_in[0] = in_data_i.elem_0;
  assign elem_in[1] = in_data_i.elem_1;
  assign elem_in[2] = in_data_i.elem_2;
  assign elem_in[3] = in_data_i.elem_3;
  assign elem_in[4] = in_data_i.elem_4;
  assign elem_in[5] = in_data_i.elem_5;
  assign elem_in[6] = in_data_i.elem_6;
  assign elem_in[7] = in_data_i.elem_7;

  always_comb begin
    bad_in = ({1'b0, in_data_i.pick_count} > 5'(MAX_PICK))
          || (in_data_i.pick_count > 4'(NF))
          || ({2'b0, in_data_i.pick_count} > n_eff);
    for (int k = 0; k < NF; k++) begin
      if (4'(k) < in_data_i.pick_count) begin
        if ({2'b0, elem_in[k]} >= n_eff) begin
          bad_in = 1'b1;
        end
        if (k > 0 && elem_in[k] <= elem_in[(k > 0) ? k - 1 : 0]) begin
          bad_in = 1'b1;
        end
      end
    end
  end

  // walk state: head of shift line is the element of the current position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NF; k++) begin
        elem_q[k] <= elem_in[k];
      end
      prev_q   <= '0;
      n_q      <= n_eff;
      j_q      <= '0;
      rem_q    <= in_data_i.pick_count - 4'd1;
      acc_q    <= '0;
      empty_q  <= (in_data_i.pick_count == 4'd0);
      single_q <= (in_data_i.pick_count == 4'd1);
      bad_q    <= bad_in;
    end else if (cmd_i.step) begin
      j_q <= j_q + EW'(1);
      if (j_q < elem_q[0]) begin
        acc_q <= acc_q + cr_pkg::BinomTab[row_full[4:0]][rem_q[2:0]];
      end else begin
        rem_q  <= rem_q - 4'd1;
        prev_q <= elem_q[0];
        for (int k = 0; k < NF - 1; k++) begin
          elem_q[k] <= elem_q[k+1];
        end
      end
    end
  end

  assign row_full = n_q - SW'(1) - {2'b0, j_q};

  assign status_o.walk_done = empty_q || bad_q || (rem_q == 4'd0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (empty_q) begin
      rank_res = cr_pkg::RankEmpty;
    end else if (bad_q) begin
      rank_res = '0;
    end else if (single_q) begin
      rank_res = RW'(elem_q[0]);
    end else begin
      rank_res = acc_q + RW'(elem_q[0] - prev_q - EW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.rank       <= rank_res;
      out_q.bad_subset <= bad_q && !empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CR_ASSERT_SAME(a_finish_done, clk_i, rst_ni, cmd_i.finish, status_o.walk_done,
                  "result written before walk finished")
  `CR_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, cmd_i.finish, !out_valid_q || out_ready_i,
                  "pending result overwritten")
  `CR_ASSERT_SAME(a_step_live, clk_i, rst_ni, cmd_i.step, !status_o.walk_done,
                  "step issued after walk finished")
  `CR_ASSERT_NEXT(a_load_clear, clk_i, rst_ni, cmd_i.load, acc_q == '0,
                  "accumulator not cleared on load")

endmodule

>>> rtl/combination_rank.sv
// Top level of combination_rank: lexicographic rank of a subset.
// Depends on cr_pkg, cr_chan_if, cr_ctrl and cr_dp.
//
//   channel  dir  payload                          handshake
//   cfg_i    in   set_size (5 b)                   valid/ready, always ready
//   in_i     in   pick_count, elem_0 .. elem_7     valid/ready
//   out_o    out  rank (15 b signed), bad_subset   valid/ready
//
// An item is loaded, walked and finished: the walk adds one binomial table
// term or advances one position per cycle, up to the last-but-one element.
// Empty, single-element and malformed subsets skip the walk.
// A result waits in the output register; the next item is taken meanwhile
// and its walk holds at the end until the output register is free.
// Reset sets set_size to 16 and empties the output register.
module combination_rank #(
  parameter int unsigned MAX_SET  = 16,
  parameter int unsigned MAX_PICK = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cr_chan_if.sink   cfg_i,
  cr_chan_if.sink   in_i,
  cr_chan_if.source out_o
);

  cr_pkg::cmd_t    cmd;
  cr_pkg::status_t status;
  logic            in_ready;
  logic            cfg_ready;
  logic            out_valid;
  cr_pkg::out_item_t out_data;

  cr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cr_dp #(
    .MAX_SET  (MAX_SET),
    .MAX_PICK (MAX_PICK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_i.data),
    .in_data_i   (in_i.data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = cfg_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

>>> dv/cr_rank_checker.sv
`timescale 1ns / 1ps
// Checker for combination_rank: watches the size, subset and rank channels,
// predicts each rank and compares it with the block's result. Depends on cr_pkg, cr_chan_if.
module cr_rank_checker #(
  parameter int unsigned MAX_SET  = 16,
  parameter int unsigned MAX_PICK = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cr_chan_if          cfg_i,
  cr_chan_if          in_i,
  cr_chan_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ReportLimit = 10;

  cr_pkg::set_size_t   size_copy;
  cr_pkg::out_item_t   rank_queue[$];
  cr_pkg::out_item_t   expected;
  int unsigned         fails;

  function automatic longint unsigned binomial(input int unsigned n, input int unsigned k);
    longint unsigned acc;
    int unsigned     kk;
    acc = 1;
    kk  = k;
    if (kk > n) return 0;
    if (kk > n - kk) kk = n - kk;
    for (int unsigned i = 0; i < kk; i++) acc = acc * (n - i) / (i + 1);
    return acc;
  endfunction

  function automatic cr_pkg::out_item_t rank_of(input cr_pkg::in_item_t item,
                                                input cr_pkg::set_size_t size);
    int unsigned       el[cr_pkg::ElemFields];
    int unsigned       n;
    int unsigned       p;
    int unsigned       start;
    longint unsigned   acc;
    logic              bad;
    cr_pkg::out_item_t res;
    n = size;
    if (n > MAX_SET) n = MAX_SET;
    p = item.pick_count;
    el[0] = item.elem_0;
    el[1] = item.elem_1;
    el[2] = item.elem_2;
    el[3] = item.elem_3;
    el[4] = item.elem_4;
    el[5] = item.elem_5;
    el[6] = item.elem_6;
    el[7] = item.elem_7;
    acc = 0;
    bad = 1'b0;
    res.rank       = '0;
    res.bad_subset = 1'b0;
    if (p == 0) begin
      res.rank = cr_pkg::RankEmpty;
      return res;
    end
    if (p > MAX_PICK || p > cr_pkg::ElemFields || p > n) bad = 1'b1;
    if (!bad) begin
      for (int unsigned i = 0; i < p; i++) begin
        if (el[i] >= n) bad = 1'b1;
        if (i > 0 && el[i] <= el[i-1]) bad = 1'b1;
      end
    end
    if (bad) begin
      res.bad_subset = 1'b1;
      return res;
    end
    if (p == 1) begin
      acc = el[0];
    end else begin
      for (int unsigned i = 0; i + 1 < p; i++) begin
        start = (i == 0) ? 0 : el[i-1] + 1;
        for (int unsigned j = start; j < el[i]; j++) acc += binomial(n - (j + 1), p - (i + 1));
      end
      acc += el[p-1] - el[p-2] - 1;
    end
    res.rank = acc[cr_pkg::RankW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_copy <= 5'd16;
      rank_queue.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) size_copy <= cfg_i.data;
      if (out_i.valid && out_i.ready) begin
        if (rank_queue.size() == 0) begin
          if (fails < ReportLimit)
            $display("%0t: unexpected rank %0d bad_subset %0b", $realtime,
                     out_i.data.rank, out_i.data.bad_subset);
          fails++;
        end else begin
          expected = rank_queue.pop_front();
          if (out_i.data.rank !== expected.rank ||
              out_i.data.bad_subset !== expected.bad_subset) begin
            if (fails < ReportLimit)
              $display("%0t: mismatch rank exp %0d got %0d, bad_subset exp %0b got %0b",
                       $realtime, expected.rank, out_i.data.rank,
                       expected.bad_subset, out_i.data.bad_subset);
            fails++;
          end
        end
      end
      if (in_i.valid && in_i.ready) rank_queue.push_back(rank_of(in_i.data, size_copy));
      pending_o <= rank_queue.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for combination_rank: clock, reset, subset stimulus, stalls
// and verdict. Depends on cr_pkg, cr_chan_if, combination_rank, cr_rank_checker.
module tb_top;

  localparam int unsigned MaxSet      = 16;
  localparam int unsigned MaxPick     = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 500;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              rx_hold;
  logic              rx_quiet;
  logic              tx_quiet;
  cr_pkg::set_size_t cur_size;
  int unsigned       sent_cnt;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycles;

  cr_chan_if #(.T(cr_pkg::set_size_t)) cfg_if ();
  cr_chan_if #(.T(cr_pkg::in_item_t))  in_if ();
  cr_chan_if #(.T(cr_pkg::out_item_t)) out_if ();

  combination_rank #(
    .MAX_SET (MaxSet),
    .MAX_PICK(MaxPick)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  cr_rank_checker #(
    .MAX_SET (MaxSet),
    .MAX_PICK(MaxPick)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_i       (cfg_if),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  function automatic cr_pkg::in_item_t random_subset(input cr_pkg::set_size_t size);
    int unsigned n;
    int unsigned p;
    int unsigned need;
    int unsigned slot;
    int unsigned pos;
    int unsigned roll;
    logic [31:0] elems;
    logic [3:0]  count;
    n = size;
    if (n > MaxSet) n = MaxSet;
    elems = $urandom();
    count = 4'($urandom_range(0, 15));
    roll  = $urandom_range(0, 99);
    if (roll < 5) begin
      count = '0;
    end else if (roll < 85 && n != 0) begin
      p    = $urandom_range(1, (n < MaxPick) ? n : MaxPick);
      need = p;
      slot = 0;
      for (int unsigned v = 0; v < n && need != 0; v++) begin
        if ($urandom_range(0, n - v - 1) < need) begin
          elems[31 - 4*slot -: 4] = 4'(v);
          slot++;
          need--;
        end
      end
      count = 4'(p);
      if (roll >= 70) begin
        pos = $urandom_range(0, p - 1);
        if (pos != 0) elems[31 - 4*pos -: 4] = elems[35 - 4*pos -: 4];
        else if (n < 16) elems[31 -: 4] = 4'($urandom_range(n, 15));
        else count = 4'($urandom_range(MaxPick + 1, 15));
      end
    end
    return {count, elems};
  endfunction

  task automatic send_item(input cr_pkg::in_item_t item);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = ~tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // drop valid and wait for every pending rank
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_size(input cr_pkg::set_size_t size);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= size;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_size = size;
  endtask

  task automatic random_run(input int unsigned count);
    repeat (count) send_item(random_subset(cur_size));
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cur_size     = 5'd16;
    sent_cnt     = 0;
    tx_quiet     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item({4'd0, 32'h5A5A_5A5A});
    send_item({4'd1, 32'h0FFF_FFFF});
    send_item({4'd1, 32'hF000_0000});
    send_item({4'd8, 32'h0123_4567});
    send_item({4'd8, 32'h89AB_CDEF});
    send_item({4'd2, 32'h0100_0000});
    send_item({4'd2, 32'hEF00_0000});
    send_item({4'd3, 32'h149F_FFFF});
    send_item({4'd7, 32'h1357_9BD0});
    send_item({4'd9, 32'h0123_4567});
    send_item({4'd15, 32'hFFFF_FFFF});
    send_item({4'd2, 32'h3300_0000});
    send_item({4'd2, 32'h5200_0000});
    send_item({4'd8, 32'h0123_4576});

    write_size(5'd5);
    send_item({4'd1, 32'h5000_0000});
    send_item({4'd2, 32'h1F00_0000});
    send_item({4'd6, 32'h0123_4500});
    send_item({4'd5, 32'h0123_4000});
    send_item({4'd3, 32'h2340_0000});
    random_run(150);

    write_size(5'd1);
    send_item({4'd1, 32'h0000_0000});
    send_item({4'd1, 32'h1000_0000});
    send_item({4'd2, 32'h0100_0000});
    random_run(60);

    write_size(5'd0);
    send_item({4'd0, 32'hFFFF_FFFF});
    send_item({4'd1, 32'h0000_0000});
    random_run(40);

    write_size(5'd31);
    send_item({4'd8, 32'h89AB_CDEF});
    random_run(150);

    write_size(5'd16);
    random_run(600);

    write_size(5'd9);
    random_run(200);

    write_size(5'd2);
    random_run(80);

    write_size(5'd13);
    random_run(170);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    gap          = 0;
    rx_quiet     = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold || gap != 0) begin
        out_if.ready <= 1'b0;
        if (!rx_hold) gap--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // hold the receiver off while the sender keeps offering items
  initial begin
    rx_hold = 1'b0;
    wait (sent_cnt >= HoldAfter);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cr_pkg.sv
rtl/cr_chan_if.sv
rtl/cr_ctrl.sv
rtl/cr_dp.sv
rtl/combination_rank.sv
dv/cr_rank_checker.sv
dv/tb_top.sv
